// ===== sv/tsb_pkg.sv =====
// ----------------------------------------------------------------------------
// Texture sampler package
// Shared types and constants of the bilinear texture sampler.
// ----------------------------------------------------------------------------
package tsb_pkg;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 9;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FILTER_MODE = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WRAP_MODE   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TEX_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TEX_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COLOR_MODE  = 3'd4;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    localparam logic [16:0] ONE_Q16  = 17'h10000;
    localparam logic [15:0] HALF_Q16 = 16'h8000;

    typedef struct packed {
        logic vld;
        logic wr;
    } t_ctl;

endpackage

// ===== sv/tsb_smp_if.sv =====
// ----------------------------------------------------------------------------
// Sample/write request channel
// Valid/ready channel carrying one sample or texel write item.
// ----------------------------------------------------------------------------
interface tsb_smp_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic signed [23:0] u_coord;
    logic signed [23:0] v_coord;
    logic [7:0]         texel_x;
    logic [7:0]         texel_y;
    logic [7:0]         in_red;
    logic [7:0]         in_green;
    logic [7:0]         in_blue;

    modport source (output valid, opcode, u_coord, v_coord, texel_x, texel_y,
                    in_red, in_green, in_blue, input ready);
    modport sink   (input valid, opcode, u_coord, v_coord, texel_x, texel_y,
                    in_red, in_green, in_blue, output ready);
endinterface

// ===== sv/tsb_res_if.sv =====
// ----------------------------------------------------------------------------
// Sample result channel
// Valid/ready channel carrying one filtered colour.
// ----------------------------------------------------------------------------
interface tsb_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;

    modport source (output valid, out_red, out_green, out_blue, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

// ===== sv/tsb_coord.sv =====
// ----------------------------------------------------------------------------
// Texture sampler coordinate stage
// Wrap or clamp, scale by size minus one, pick neighbour and distance weight.
// ----------------------------------------------------------------------------
module tsb_coord
    import tsb_pkg::*;
#(
    parameter int SIZE_MAX = 256,
    parameter int IW       = $clog2(SIZE_MAX)
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [23:0]  i_coord,
    input  logic [8:0]          i_size,
    input  logic                i_wrap_mode,
    input  logic                i_filter_mode,
    output logic [IW-1:0]       o_p,
    output logic [IW-1:0]       o_a,
    output logic [15:0]         o_d
);

    logic [15:0]    size_ext;
    logic [15:0]    eff_size;
    logic [IW-1:0]  size_m1;
    logic [16:0]    n_wrap;
    logic [16:0]    r_wrap;
    logic [IW+15:0] r_fu;
    logic [IW-1:0]  p;
    logic [15:0]    frac;
    logic [IW-1:0]  n_a;
    logic [15:0]    n_d;

    always_comb begin
        size_ext = 16'(i_size);
        if (size_ext == 16'd0) begin
            eff_size = 16'd1;
        end else if (size_ext > 16'(SIZE_MAX)) begin
            eff_size = 16'(SIZE_MAX);
        end else begin
            eff_size = size_ext;
        end
        size_m1 = IW'(eff_size - 16'd1);
    end

    always_comb begin
        if (!i_wrap_mode) begin
            n_wrap = {1'b0, i_coord[15:0]};
        end else if (i_coord[23]) begin
            n_wrap = 17'd0;
        end else if (24'(i_coord) > 24'(ONE_Q16)) begin
            n_wrap = ONE_Q16;
        end else begin
            n_wrap = i_coord[16:0];
        end
    end

    assign p    = r_fu[IW+15:16];
    assign frac = r_fu[15:0];

    always_comb begin
        if (frac > HALF_Q16) begin
            n_a = (p == size_m1) ? size_m1 : p + IW'(1);
            n_d = frac - HALF_Q16;
        end else begin
            n_a = (p == '0) ? '0 : p - IW'(1);
            n_d = HALF_Q16 - frac;
        end
        if (!i_filter_mode) begin
            n_d = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wrap <= n_wrap;
            r_fu   <= (IW+16)'((IW+17)'(r_wrap) * (IW+17)'(size_m1));
            o_p    <= p;
            o_a    <= n_a;
            o_d    <= n_d;
        end
    end

endmodule

// ===== sv/tsb_store.sv =====
// ----------------------------------------------------------------------------
// Texture sampler texel store
// Two mirrored texel memories, each giving two registered reads a cycle.
// ----------------------------------------------------------------------------
module tsb_store
    import tsb_pkg::*;
#(
    parameter int XW = 8,
    parameter int YW = 8,
    parameter int DW = 24
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic          i_we,
    input  logic [XW-1:0] i_wx,
    input  logic [YW-1:0] i_wy,
    input  logic [DW-1:0] i_wdata,
    input  logic [XW-1:0] i_pu,
    input  logic [XW-1:0] i_au,
    input  logic [YW-1:0] i_pv,
    input  logic [YW-1:0] i_av,
    output logic [DW-1:0] o_q00,
    output logic [DW-1:0] o_q10,
    output logic [DW-1:0] o_q01,
    output logic [DW-1:0] o_q11
);

    localparam int DEPTH = 2 ** (XW + YW);

    logic [DW-1:0] mem_row_p [DEPTH];
    logic [DW-1:0] mem_row_a [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en && i_we) begin
            mem_row_p[{i_wy, i_wx}] <= i_wdata;
        end
        if (i_en) begin
            o_q00 <= mem_row_p[{i_pv, i_pu}];
            o_q10 <= mem_row_p[{i_pv, i_au}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_we) begin
            mem_row_a[{i_wy, i_wx}] <= i_wdata;
        end
        if (i_en) begin
            o_q01 <= mem_row_a[{i_av, i_pu}];
            o_q11 <= mem_row_a[{i_av, i_au}];
        end
    end

endmodule

// ===== sv/tsb_blend.sv =====
// ----------------------------------------------------------------------------
// Texture sampler blend
// Weight products, per-channel products and rounded four-texel sum.
// ----------------------------------------------------------------------------
module tsb_blend
    import tsb_pkg::*;
#(
    parameter int CB = 8
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [15:0]     i_du,
    input  logic [15:0]     i_dv,
    input  logic            i_mono,
    input  logic [3*CB-1:0] i_q00,
    input  logic [3*CB-1:0] i_q10,
    input  logic [3*CB-1:0] i_q01,
    input  logic [3*CB-1:0] i_q11,
    output logic [2:0][7:0] o_ch
);

    localparam int PW = CB + 33;
    localparam int SW = CB + 34;

    logic [16:0] eu;
    logic [16:0] ev;
    logic [32:0] r_w00;
    logic [32:0] r_w10;
    logic [32:0] r_w01;
    logic [32:0] r_w11;

    assign eu = ONE_Q16 - 17'(i_du);
    assign ev = ONE_Q16 - 17'(i_dv);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w00 <= 33'(eu) * 33'(ev);
            r_w10 <= 33'(i_du) * 33'(ev);
            r_w01 <= 33'(eu) * 33'(i_dv);
            r_w11 <= 33'(i_du) * 33'(i_dv);
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_ch
        localparam int SEL = c * CB;

        logic [CB-1:0] t00;
        logic [CB-1:0] t10;
        logic [CB-1:0] t01;
        logic [CB-1:0] t11;
        logic [PW-1:0] r_m00;
        logic [PW-1:0] r_m10;
        logic [PW-1:0] r_m01;
        logic [PW-1:0] r_m11;
        logic [SW-1:0] acc;
        logic [15:0]   val;

        assign t00 = i_mono ? i_q00[CB-1:0] : i_q00[SEL +: CB];
        assign t10 = i_mono ? i_q10[CB-1:0] : i_q10[SEL +: CB];
        assign t01 = i_mono ? i_q01[CB-1:0] : i_q01[SEL +: CB];
        assign t11 = i_mono ? i_q11[CB-1:0] : i_q11[SEL +: CB];

        assign acc = SW'(r_m00) + SW'(r_m10) + SW'(r_m01) + SW'(r_m11)
                   + SW'(34'h080000000);
        assign val = 16'(acc >> 32);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m00   <= PW'(t00) * PW'(r_w00);
                r_m10   <= PW'(t10) * PW'(r_w10);
                r_m01   <= PW'(t01) * PW'(r_w01);
                r_m11   <= PW'(t11) * PW'(r_w11);
                o_ch[c] <= val[7:0];
            end
        end
    end

endmodule

// ===== sv/texture_sampler_bilinear_core.sv =====
// ----------------------------------------------------------------------------
// Bilinear texture sampler core
// Items enter on i_smp: a write item stores one texel, a sample item wraps or
// clamps and scales u,v, reads four texels and returns their weighted blend
// (or the nearest texel) on o_res. Writes give no result. The user must set
// registers through the i_cfg_* write port only while the block is idle;
// the block does not enforce it. Throughput: one item per cycle. A sample
// result passes coordinate, store and blend registers; the store reads and
// writes in the fourth stage, so a sample sees all writes accepted before it.
// Four reads a cycle come from two mirrored memories with two read ports.
// All stages advance together; while o_res holds a result that is not taken
// the whole pipeline holds and i_smp.ready is low, so nothing is lost.
// Reset clears the stage valid bits and loads the register defaults; the
// texel store is not cleared and must be written before it is sampled.
// ----------------------------------------------------------------------------
module texture_sampler_bilinear_core
    import tsb_pkg::*;
#(
    parameter int MAX_WIDTH    = 256,
    parameter int MAX_HEIGHT   = 256,
    parameter int CHANNEL_BITS = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    tsb_smp_if.sink                  i_smp,
    tsb_res_if.source                o_res,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int CB = CHANNEL_BITS;
    localparam int DW = 3 * CB;

    logic       r_filter_mode;
    logic       r_wrap_mode;
    logic [8:0] r_tex_width;
    logic [8:0] r_tex_height;
    logic       r_color_mode;

    logic en;
    t_ctl r_s1, r_s2, r_s3, r_s4, r_s5;
    logic r_out_vld;

    logic          r_ok1, r_ok2, r_ok3;
    logic [XW-1:0] r_x1, r_x2, r_x3;
    logic [YW-1:0] r_y1, r_y2, r_y3;
    logic [DW-1:0] r_d1, r_d2, r_d3;
    logic          n_ok;

    logic [XW-1:0] pu, au;
    logic [YW-1:0] pv, av;
    logic [15:0]   du, dv;
    logic [DW-1:0] q00, q10, q01, q11;
    logic [2:0][7:0] ch;

    assign en          = !r_out_vld || o_res.ready;
    assign i_smp.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_mode <= 1'b0;
            r_wrap_mode   <= 1'b1;
            r_tex_width   <= 9'd256;
            r_tex_height  <= 9'd256;
            r_color_mode  <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FILTER_MODE: r_filter_mode <= i_cfg_data[0];
                CFG_WRAP_MODE:   r_wrap_mode   <= i_cfg_data[0];
                CFG_TEX_WIDTH:   r_tex_width   <= i_cfg_data;
                CFG_TEX_HEIGHT:  r_tex_height  <= i_cfg_data;
                CFG_COLOR_MODE:  r_color_mode  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1      <= '0;
            r_s2      <= '0;
            r_s3      <= '0;
            r_s4      <= '0;
            r_s5      <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_s1      <= '{vld: i_smp.valid, wr: i_smp.opcode == OP_WRITE};
            r_s2      <= r_s1;
            r_s3      <= r_s2;
            r_s4      <= r_s3;
            r_s5      <= r_s4;
            r_out_vld <= r_s5.vld && !r_s5.wr;
        end
    end

    assign n_ok = (16'(i_smp.texel_x) < 16'(MAX_WIDTH))
               && (16'(i_smp.texel_y) < 16'(MAX_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ok1 <= n_ok;
            r_x1  <= XW'(16'(i_smp.texel_x));
            r_y1  <= YW'(16'(i_smp.texel_y));
            r_d1  <= {CB'(i_smp.in_blue), CB'(i_smp.in_green), CB'(i_smp.in_red)};
            r_ok2 <= r_ok1;
            r_x2  <= r_x1;
            r_y2  <= r_y1;
            r_d2  <= r_d1;
            r_ok3 <= r_ok2;
            r_x3  <= r_x2;
            r_y3  <= r_y2;
            r_d3  <= r_d2;
        end
    end

    tsb_coord #(.SIZE_MAX(MAX_WIDTH), .IW(XW)) u_coord_u (
        .i_clk         (i_clk),
        .i_en          (en),
        .i_coord       (i_smp.u_coord),
        .i_size        (r_tex_width),
        .i_wrap_mode   (r_wrap_mode),
        .i_filter_mode (r_filter_mode),
        .o_p           (pu),
        .o_a           (au),
        .o_d           (du)
    );

    tsb_coord #(.SIZE_MAX(MAX_HEIGHT), .IW(YW)) u_coord_v (
        .i_clk         (i_clk),
        .i_en          (en),
        .i_coord       (i_smp.v_coord),
        .i_size        (r_tex_height),
        .i_wrap_mode   (r_wrap_mode),
        .i_filter_mode (r_filter_mode),
        .o_p           (pv),
        .o_a           (av),
        .o_d           (dv)
    );

    tsb_store #(.XW(XW), .YW(YW), .DW(DW)) u_store (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_we    (r_s3.vld && r_s3.wr && r_ok3),
        .i_wx    (r_x3),
        .i_wy    (r_y3),
        .i_wdata (r_d3),
        .i_pu    (pu),
        .i_au    (au),
        .i_pv    (pv),
        .i_av    (av),
        .o_q00   (q00),
        .o_q10   (q10),
        .o_q01   (q01),
        .o_q11   (q11)
    );

    tsb_blend #(.CB(CB)) u_blend (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_du   (du),
        .i_dv   (dv),
        .i_mono (!r_color_mode),
        .i_q00  (q00),
        .i_q10  (q10),
        .i_q01  (q01),
        .i_q11  (q11),
        .o_ch   (ch)
    );

    assign o_res.valid     = r_out_vld;
    assign o_res.out_red   = ch[0];
    assign o_res.out_green = ch[1];
    assign o_res.out_blue  = ch[2];

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_s5.vld && r_s5.wr |=> !o_res.valid)
        else $error("write item produced a result");

    a_sample_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_s5.vld && !r_s5.wr |=> o_res.valid)
        else $error("sample item lost before output");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid && !r_s1.vld && !r_s5.vld)
        else $error("pipeline valid bits not cleared by reset");

endmodule
